// ===== hdl/mco_pkg.sv =====
// Shared constants and types for the midpoint circle outline block.
`default_nettype none
package mco_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int OUT_BITS    = 14;
    localparam int OCT_BITS    = 3;
    localparam int DEC_BITS    = RADIUS_BITS + 6;
    localparam int OFS_BITS    = RADIUS_BITS + 2;
    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic [OCT_BITS-1:0] OCT_LAST = OCT_BITS'(7);

    typedef logic        [COORD_BITS-1:0]  t_coord;
    typedef logic        [RADIUS_BITS-1:0] t_radius;
    typedef logic signed [OFS_BITS-1:0]    t_ofs;
    typedef logic signed [DEC_BITS-1:0]    t_dec;
    typedef logic signed [OUT_BITS-1:0]    t_point;
    typedef logic        [OCT_BITS-1:0]    t_oct;

    // One iteration handed from the front to the back.
    typedef struct packed {
        t_coord cx;
        t_coord cy;
        t_ofs   a;
        t_ofs   b;
        logic   done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== hdl/mco_if.sv =====
// Valid/ready channel interfaces for the circle outline input and output.
`default_nettype none
interface mco_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [mco_pkg::COORD_BITS-1:0] center_x;
    logic [mco_pkg::COORD_BITS-1:0] center_y;

    modport source (output valid, action, center_x, center_y, input ready);
    modport sink   (input valid, action, center_x, center_y, output ready);
endinterface

interface mco_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [mco_pkg::OUT_BITS-1:0] point_x;
    logic signed [mco_pkg::OUT_BITS-1:0] point_y;
    logic [mco_pkg::OCT_BITS-1:0]        octant;
    logic                             last_point;

    modport source (output valid, point_x, point_y, octant, last_point, input ready);
    modport sink   (input valid, point_x, point_y, octant, last_point, output ready);
endinterface
`default_nettype wire

// ===== hdl/mco_front.sv =====
// Front end: accepts items, runs the midpoint recurrence, queues iterations.
`default_nettype none
module mco_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire mco_pkg::t_radius i_cfg_data,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_action,
    input  wire mco_pkg::t_coord i_center_x,
    input  wire mco_pkg::t_coord i_center_y,
    input  wire mco_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output mco_pkg::t_job        o_job
);
    import mco_pkg::*;

    t_radius r_radius;
    t_coord  r_cx, r_cy;
    t_ofs    r_x, r_y;
    t_dec    r_d;
    logic    r_running;

    t_ofs n_x, n_y;
    t_dec n_d;
    logic step_y, done, take;

    assign o_ready = !i_q_stat.full;
    assign take    = i_valid && o_ready;

    always_comb begin
        step_y = !r_d[DEC_BITS-1] && (r_d != '0);
        n_x    = r_x + OFS_BITS'(1);
        if (step_y) begin
            n_y = r_y - OFS_BITS'(1);
            n_d = r_d + ((DEC_BITS'(n_x) - DEC_BITS'(n_y)) <<< 2) + DEC_BITS'(10);
        end else begin
            n_y = r_y;
            n_d = r_d + (DEC_BITS'(n_x) <<< 2) + DEC_BITS'(6);
        end
        done = (n_y < n_x);
    end

    assign o_push = take && (i_action == ACT_ADVANCE) && r_running;
    assign o_job  = '{cx: r_cx, cy: r_cy, a: r_x, b: r_y, done: done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_BITS'(1);
            r_running <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            if (take && (i_action == ACT_START)) begin
                r_running <= 1'b1;
            end else if (o_push && done) begin
                r_running <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && (i_action == ACT_START)) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_x  <= '0;
            r_y  <= OFS_BITS'(r_radius);
            r_d  <= DEC_BITS'(3) - (DEC_BITS'(r_radius) << 1);
        end else if (o_push && !done) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= n_d;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mco_queue.sv =====
// Two-entry job queue between the front and back ends.
`default_nettype none
module mco_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mco_pkg::t_job i_job,
    input  wire logic          i_pop,
    output mco_pkg::t_job      o_head,
    output mco_pkg::t_q_stat   o_stat
);
    import mco_pkg::*;

    t_job                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QCNT_BITS-1:0] r_cnt;
    logic                 do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCNT_BITS'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_BITS'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_BITS'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mco_back.sv =====
// Back end: queue head to eight symmetric points, one per cycle unless stalled
`default_nettype none
module mco_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mco_pkg::t_job    i_head,
    input  wire mco_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output mco_pkg::t_point       o_point_x,
    output mco_pkg::t_point       o_point_y,
    output mco_pkg::t_oct         o_octant,
    output logic                  o_last_point
);
    import mco_pkg::*;

    t_oct   r_k;
    logic   r_valid;
    t_point r_px, r_py;
    t_oct   r_oct;
    logic   r_last;

    logic   load;
    t_ofs   u, v;
    t_point cx, cy, du, dv, n_px, n_py;

    assign load  = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_pop = load && (r_k == OCT_LAST);

    always_comb begin
        // octants 4..7 swap the roles of the two offsets
        u    = r_k[2] ? i_head.b : i_head.a;
        v    = r_k[2] ? i_head.a : i_head.b;
        cx   = OUT_BITS'(i_head.cx);
        cy   = OUT_BITS'(i_head.cy);
        du   = OUT_BITS'(u);
        dv   = OUT_BITS'(v);
        n_px = r_k[0] ? (cx - du) : (cx + du);
        n_py = r_k[1] ? (cy - dv) : (cy + dv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k     <= r_k + OCT_BITS'(1);
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_oct  <= r_k;
            r_last <= i_head.done && (r_k == OCT_LAST);
        end
    end

    assign o_valid      = r_valid;
    assign o_point_x    = r_px;
    assign o_point_y    = r_py;
    assign o_octant     = r_oct;
    assign o_last_point = r_last;

endmodule
`default_nettype wire

// ===== hdl/midpoint_circle_outline.sv =====
// Top level of the midpoint circle outline generator.
// Usage:
//   i_cfg_we/i_cfg_data write the radius (reset value 1); a start samples it.
//   i_in carries items: action 0 starts a circle at center_x/center_y and
//   produces no output; action 1 runs one iteration and yields eight points
//   on o_out in octant order 0..7, the final point of the circle flagged by
//   last_point. An advance with no circle in progress yields nothing.
// Timing:
//   An accepted advance is written into the job queue; its octant 0 point
//   then loads into the output register and the rest follow one point per
//   cycle while the receiver is ready. The single output register moves one
//   point per transfer, so an advance yields eight transfers; the front
//   parks up to two iterations in the job queue, so input transfers keep
//   flowing while the back end drains points.
// Stall and reset:
//   When the receiver drops ready the output point holds and the back end
//   freezes; the front keeps taking items until the queue fills, then drops
//   i_in.ready. Reset (synchronous, active low) empties the queue and the
//   output register, ends any circle in progress and restores radius 1.
`default_nettype none
module midpoint_circle_outline (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire mco_pkg::t_radius i_cfg_data,
    mco_in_if.sink                i_in,
    mco_out_if.source             o_out
);
    import mco_pkg::*;

    // front to queue
    logic    push;
    t_job    job;
    // queue to back
    t_job    head;
    t_q_stat q_stat;
    logic    pop;

    // Run the recurrence and classify items: starts reload, advances queue.
    mco_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_action   (i_in.action),
        .i_center_x (i_in.center_x),
        .i_center_y (i_in.center_y),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (job)
    );

    // Decouple the two ends so each side can stall on its own.
    mco_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Expand the head iteration; drop it from the queue after octant 7.
    mco_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_point_x    (o_out.point_x),
        .o_point_y    (o_out.point_y),
        .o_octant     (o_out.octant),
        .o_last_point (o_out.last_point)
    );

endmodule
`default_nettype wire

// ===== hdl/mco_checker.sv =====
// Port-level assertions for the circle outline generator, bound to the top.
`default_nettype none
module mco_checker (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [mco_pkg::OCT_BITS-1:0] i_octant,
    input wire logic                   i_last_point
);
    import mco_pkg::*;

    // a pending point stays up until the receiver takes it
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output point dropped before transfer");

    a_last_oct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_point |-> i_octant == OCT_LAST)
        else $error("last_point on an octant other than the final one");

    // points of one iteration follow each other without gaps
    a_octant_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_octant != OCT_LAST)
        |=> i_out_valid && (i_octant == $past(i_octant) + OCT_BITS'(1)))
        else $error("octant sequence broken inside an iteration");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind midpoint_circle_outline mco_checker u_mco_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_octant     (o_out.octant),
    .i_last_point (o_out.last_point)
);
`default_nettype wire

// ===== bench/mco_score_pkg.sv =====
// Scoreboard for the circle outline bench: midpoint predictor and point checker.
package mco_score_pkg;

    import mco_pkg::*;

    typedef struct packed {
        t_point px;
        t_point py;
        t_oct   oct;
        logic   last;
    } t_pixel;

    class outline_scoreboard;

        t_radius radius;
        t_coord  org_x;
        t_coord  org_y;
        int      ofs_x;
        int      ofs_y;
        t_dec    dec;
        bit      drawing;
        t_pixel  pixel_q[$];
        int      mismatches;

        function new();
            radius     = 1;
            org_x      = '0;
            org_y      = '0;
            ofs_x      = 0;
            ofs_y      = 0;
            dec        = '0;
            drawing    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_radius(t_radius r);
            radius = r;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function bit is_drawing();
            return drawing;
        endfunction

        // Run one accepted item through the recurrence and queue its points.
        function void note_item(logic act, t_coord cx, t_coord cy);
            int     nx;
            int     ny;
            int     nd;
            int     u;
            int     v;
            bit     done;
            t_oct   o;
            t_pixel p;
            if (act == ACT_START) begin
                org_x   = cx;
                org_y   = cy;
                ofs_x   = 0;
                ofs_y   = int'(radius);
                dec     = t_dec'(3 - 2 * int'(radius));
                drawing = 1'b1;
                return;
            end
            if (!drawing)
                return;
            nx = ofs_x + 1;
            ny = ofs_y;
            if (dec > 0) begin
                ny = ny - 1;
                nd = int'(dec) + 4 * (nx - ny) + 10;
            end else begin
                nd = int'(dec) + 4 * nx + 6;
            end
            done = (ny < nx);
            // bit 0 mirrors x, bit 1 mirrors y, bit 2 swaps the offsets
            for (int k = 0; k <= int'(OCT_LAST); k++) begin
                o      = t_oct'(k);
                u      = o[2] ? ofs_y : ofs_x;
                v      = o[2] ? ofs_x : ofs_y;
                p.px   = t_point'(o[0] ? int'(org_x) - u : int'(org_x) + u);
                p.py   = t_point'(o[1] ? int'(org_y) - v : int'(org_y) + v);
                p.oct  = o;
                p.last = done && (o == OCT_LAST);
                pixel_q.push_back(p);
            end
            if (done) begin
                drawing = 1'b0;
            end else begin
                ofs_x = nx;
                ofs_y = ny;
                dec   = t_dec'(nd);
            end
        endfunction

        function void check_point(t_point px, t_point py, t_oct oct, logic last);
            t_pixel want;
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point: x=%0d y=%0d oct=%0d last=%b",
                             px, py, oct, last);
                return;
            end
            want = pixel_q.pop_front();
            if (px !== want.px || py !== want.py || oct !== want.oct ||
                last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("point mismatch: expected x=%0d y=%0d oct=%0d last=%b",
                             want.px, want.py, want.oct, want.last);
                    $display("                got      x=%0d y=%0d oct=%0d last=%b",
                             px, py, oct, last);
                end
            end
        endfunction

        // Count leftover expectations as one more failure.
        function int failures();
            if (pixel_q.size() != 0) begin
                $display("%0d expected points never arrived", pixel_q.size());
                return mismatches + 1;
            end
            return mismatches;
        endfunction

    endclass

endpackage

// ===== bench/tb_midpoint_circle_outline.sv =====
// Self-checking bench for the midpoint circle outline generator.
module tb_midpoint_circle_outline;

    import mco_pkg::*;
    import mco_score_pkg::*;

    localparam int ITEMS_TOTAL    = 380;
    localparam int SETTLE_CYCLES  = 8;     // covers an advance still in flight
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    cfg_we;
    t_radius cfg_data;

    mco_in_if  in_if ();
    mco_out_if out_if ();

    midpoint_circle_outline dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    outline_scoreboard sb = new();

    bit      in_held   = 1'b0;  // input valid currently driven high
    bit      idle_on   = 1'b1;  // random bubbles on both sides
    bit      long_hold = 1'b0;  // request for one long receiver hold-off
    int      items_sent = 0;
    int      quiet_cycles = 0;
    t_radius cur_radius = 1;

    always #5 i_clk = ~i_clk;

    // Check every output transfer against the oldest predicted point.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_point(out_if.point_x, out_if.point_y, out_if.octant,
                           out_if.last_point);
    end

    // Watchdog: end the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_midpoint_circle_outline NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, open stretches, and one long hold-off on request.
    initial begin
        out_if.ready = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (long_hold) begin
                out_if.ready <= 1'b0;
                long_hold = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return t_coord'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic drop_valid();
        if (in_held) begin
            in_if.valid <= 1'b0;
            in_held = 1'b0;
        end
    endtask

    // Offer one item, hold it until the transfer, then feed the predictor.
    task automatic send_item(logic act, t_coord cx, t_coord cy);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.action   <= act;
        in_if.center_x <= cx;
        in_if.center_y <= cy;
        in_held = 1'b1;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        sb.note_item(act, cx, cy);
        items_sent++;
    endtask

    // Stop offering, wait for every predicted point, then let the block go quiet.
    task automatic settle();
        drop_valid();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the radius only once the block has drained.
    task automatic write_radius(t_radius r);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= r;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_radius(r);
        cur_radius = r;
    endtask

    // Start a circle, advance until it ends or the cap is hit, then pad with
    // advances that should be ignored once the circle is finished.
    task automatic draw_circle(t_coord cx, t_coord cy, int max_adv, int extra);
        int n;
        n = 0;
        send_item(ACT_START, cx, cy);
        while (sb.is_drawing() && n < max_adv) begin
            send_item(ACT_ADVANCE, rand_coord(), rand_coord());
            n++;
        end
        repeat (extra) send_item(ACT_ADVANCE, rand_coord(), rand_coord());
    endtask

    initial begin
        int max_adv;
        in_if.valid    = 1'b0;
        in_if.action   = ACT_START;
        in_if.center_x = '0;
        in_if.center_y = '0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Advance with no circle in progress: nothing comes out.
        send_item(ACT_ADVANCE, '1, '1);
        // Reset radius at the origin corner: negative coordinates appear.
        draw_circle('0, '0, 100, 1);
        // Zero radius: one iteration of eight points on the center.
        write_radius('0);
        draw_circle('1, '1, 100, 1);
        // Largest radius, then change it mid-circle: the circle keeps its radius.
        write_radius('1);
        draw_circle(t_coord'(4095), '0, 4, 0);
        write_radius(t_radius'(5));
        send_item(ACT_ADVANCE, '0, '1);
        send_item(ACT_ADVANCE, '1, '0);
        // Start over at the new radius, abandoning the big circle.
        draw_circle(t_coord'(2048), t_coord'(1365), 100, 1);

        // Long receiver hold-off while the sender keeps offering a full circle.
        write_radius(t_radius'(20));
        long_hold = 1'b1;
        draw_circle(rand_coord(), rand_coord(), 100, 0);

        while (items_sent < ITEMS_TOTAL) begin
            // Drop the bubbles for the last part of the run.
            if (items_sent >= ITEMS_TOTAL * 85 / 100)
                idle_on = 1'b0;
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: write_radius('1);
                    1: write_radius(t_radius'($urandom_range(41, 1022)));
                    2, 3: write_radius(t_radius'($urandom_range(13, 40)));
                    default: write_radius(t_radius'($urandom_range(0, 12)));
                endcase
            end
            // Keep big circles short; abandon some small ones part way.
            if (cur_radius > 40)
                max_adv = $urandom_range(1, 12);
            else if ($urandom_range(0, 9) < 3)
                max_adv = $urandom_range(0, 6);
            else
                max_adv = 1000;
            draw_circle(rand_coord(), rand_coord(), max_adv,
                        ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2));
            if ($urandom_range(0, 7) == 0)
                send_item(logic'($urandom_range(0, 1)), rand_coord(), rand_coord());
        end

        idle_on = 1'b0;
        settle();
        if (sb.failures() == 0)
            $display("tb_midpoint_circle_outline OK");
        else
            $display("tb_midpoint_circle_outline NOT OK");
        $finish;
    end

endmodule
